FILE: rtl/core/rme_pkg.sv
// shared types and codes for the modular exponentiation core
// no dependencies; used by rme_mulmod and rsa_modular_exponentiation_core
package rme_pkg;

    // sequencer states of the exponentiation loop
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } state_t;

    // opcode carried in the input tuser
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // register indexes on the apb port
    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

    // status of the serial modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

FILE: rtl/core/rsa_modular_exponentiation_core.sv
// modular exponentiation core: value_in ^ exponent mod modulus, square-and-multiply
// depends on rme_pkg and rme_mulmod
//
//  channel   | ports          | payload (low bit up)
//  ----------+----------------+----------------------------------------
//  input     | s_tvalid/ready | tdata: value_in; tuser: opcode
//  result    | m_tvalid/ready | tdata: value_out; tuser: modulus_error
//  config    | apb psel..     | modulus, public_exponent, private_exponent
//
// each item runs the bit-serial multiplier (WIDTH steps per product) once to reduce the value,
// then once per square and once per set exponent bit.
// a zero modulus skips the multiplier and goes straight to the finish state for its error beat.
// reset is synchronous, active low, and sets all three registers to 1.
// a new beat is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register; a second waiting result stalls the sequencer.
module rsa_modular_exponentiation_core #(
    parameter int WIDTH = 32,
    localparam int APB_DW   = (WIDTH > 32) ? 64 : 32,
    localparam int STRIDE_L = (WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W   = $clog2(3 * (1 << STRIDE_L)),
    localparam int DATA_W   = ((WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [DATA_W-1:0]             s_tdata,   // value_in
    input  logic                          s_tuser,   // opcode
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [DATA_W-1:0]             m_tdata,   // value_out
    output logic                          m_tuser    // modulus_error
);

    localparam int CW       = $clog2(WIDTH);

    rme_pkg::state_t state_reg;
    rme_pkg::state_t state_next;

    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] pub_exp_reg;
    logic [WIDTH-1:0] priv_exp_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [CW-1:0]    bit_cnt_reg;
    logic             err_reg;
    logic             m_valid_reg;
    logic [WIDTH-1:0] m_value_reg;
    logic             m_err_reg;

    logic [1:0]       reg_idx;
    logic             cfg_write;
    logic             s_accept;
    logic             out_load;
    logic             last_bit;
    logic [WIDTH-1:0] one_mod;
    logic [WIDTH-1:0] value_in;

    logic              mm_start;
    logic [WIDTH-1:0]  mm_a;
    logic [WIDTH-1:0]  mm_b;
    rme_pkg::mm_stat_t mm_stat;
    logic [WIDTH-1:0]  mm_result;

    assign value_in = s_tdata[WIDTH-1:0];
    assign reg_idx  = paddr[ADDR_W-1:STRIDE_L];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign s_accept = s_tvalid && s_tready;
    assign last_bit = (bit_cnt_reg == '0);
    // 1 mod n, which is 0 when n is 1
    assign one_mod  = {{(WIDTH-1){1'b0}}, (modulus_reg != {{(WIDTH-1){1'b0}}, 1'b1})};

    // register read mux
    always_comb begin
        unique case (reg_idx)
            rme_pkg::REG_MODULUS:     prdata = APB_DW'(modulus_reg);
            rme_pkg::REG_PUBLIC_EXP:  prdata = APB_DW'(pub_exp_reg);
            rme_pkg::REG_PRIVATE_EXP: prdata = APB_DW'(priv_exp_reg);
            default:                  prdata = '0;
        endcase
    end

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= {{(WIDTH-1){1'b0}}, 1'b1};
            pub_exp_reg  <= {{(WIDTH-1){1'b0}}, 1'b1};
            priv_exp_reg <= {{(WIDTH-1){1'b0}}, 1'b1};
        end else if (cfg_write) begin
            unique case (reg_idx)
                rme_pkg::REG_MODULUS:     modulus_reg  <= pwdata[WIDTH-1:0];
                rme_pkg::REG_PUBLIC_EXP:  pub_exp_reg  <= pwdata[WIDTH-1:0];
                rme_pkg::REG_PRIVATE_EXP: priv_exp_reg <= pwdata[WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rme_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (modulus_reg == '0) ? rme_pkg::ST_FINISH
                                                      : rme_pkg::ST_REDUCE;
                end
            end
            rme_pkg::ST_REDUCE: begin
                if (mm_stat.done) begin
                    state_next = rme_pkg::ST_SQUARE;
                end
            end
            rme_pkg::ST_SQUARE: begin
                if (mm_stat.done) begin
                    if (exp_reg[WIDTH-1]) begin
                        state_next = rme_pkg::ST_MULT;
                    end else if (last_bit) begin
                        state_next = rme_pkg::ST_FINISH;
                    end
                end
            end
            rme_pkg::ST_MULT: begin
                if (mm_stat.done) begin
                    state_next = last_bit ? rme_pkg::ST_FINISH : rme_pkg::ST_SQUARE;
                end
            end
            rme_pkg::ST_FINISH: begin
                if (out_load) begin
                    state_next = rme_pkg::ST_IDLE;
                end
            end
            default: state_next = rme_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier launch and operands, handshakes
    always_comb begin
        mm_start = 1'b0;
        mm_a     = mm_result;
        mm_b     = mm_result;
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            rme_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                mm_a     = one_mod;
                mm_b     = value_in;
                mm_start = s_accept && (modulus_reg != '0);
            end
            rme_pkg::ST_REDUCE: begin
                mm_a     = acc_reg;
                mm_b     = acc_reg;
                mm_start = mm_stat.done;
            end
            rme_pkg::ST_SQUARE: begin
                if (exp_reg[WIDTH-1]) begin
                    mm_b = base_reg;
                end
                mm_start = mm_stat.done && (exp_reg[WIDTH-1] || !last_bit);
            end
            rme_pkg::ST_MULT: begin
                mm_start = mm_stat.done && !last_bit;
            end
            rme_pkg::ST_FINISH: begin
                out_load = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    // sequencer state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rme_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // exponent shift register, bit counter and accumulator
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rme_pkg::ST_IDLE: begin
                if (s_accept) begin
                    exp_reg     <= (s_tuser == rme_pkg::OP_DECRYPT) ? priv_exp_reg
                                                                    : pub_exp_reg;
                    err_reg     <= (modulus_reg == '0);
                    acc_reg     <= one_mod;
                    bit_cnt_reg <= CW'(WIDTH - 1);
                end
            end
            rme_pkg::ST_REDUCE: begin
                if (mm_stat.done) begin
                    base_reg <= mm_result;
                end
            end
            rme_pkg::ST_SQUARE: begin
                if (mm_stat.done) begin
                    acc_reg <= mm_result;
                    if (!exp_reg[WIDTH-1]) begin
                        exp_reg     <= {exp_reg[WIDTH-2:0], 1'b0};
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
            end
            rme_pkg::ST_MULT: begin
                if (mm_stat.done) begin
                    acc_reg     <= mm_result;
                    exp_reg     <= {exp_reg[WIDTH-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= err_reg ? '0 : acc_reg;
            m_err_reg   <= err_reg;
        end
    end

    rme_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .a       (mm_a),
        .b       (mm_b),
        .n       (modulus_reg),
        .stat    (mm_stat),
        .result  (mm_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(m_value_reg);
    assign m_tuser  = m_err_reg;

endmodule

FILE: rtl/core/rme_mulmod.sv
// bit-serial modular multiplier: result = a * b mod n by add-and-double
// one multiplier bit per cycle, msb first; depends on rme_pkg
module rme_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    input  logic [WIDTH-1:0]   n,
    output rme_pkg::mm_stat_t  stat,
    output logic [WIDTH-1:0]   result
);

    localparam int CW = $clog2(WIDTH);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] r_next;

    logic [WIDTH-1:0] a_sel;
    logic [WIDTH+1:0] t_sum;
    logic [WIDTH+1:0] n_one;
    logic [WIDTH+1:0] n_two;
    logic [WIDTH+1:0] t_minus_one;
    logic [WIDTH+1:0] t_minus_two;

    // one step: 2r + bit*a stays below 3n, so pick among t, t-n, t-2n
    always_comb begin
        a_sel       = b_reg[WIDTH-1] ? a_reg : '0;
        t_sum       = {1'b0, r_reg, 1'b0} + {2'b00, a_sel};
        n_one       = {2'b00, n};
        n_two       = {1'b0, n, 1'b0};
        t_minus_one = t_sum - n_one;
        t_minus_two = t_sum - n_two;
        if (t_sum >= n_two) begin
            r_next = t_minus_two[WIDTH-1:0];
        end else if (t_sum >= n_one) begin
            r_next = t_minus_one[WIDTH-1:0];
        end else begin
            r_next = t_sum[WIDTH-1:0];
        end
    end

    // control: step counter and busy/done flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // operands and accumulator; multiplier bits shift out msb first
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end else if (busy_reg) begin
            b_reg <= {b_reg[WIDTH-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_reg;

endmodule

FILE: tb/sv/testbench.sv
// testbench for rsa_modular_exponentiation_core: apb key setup and streamed encrypt/decrypt beats
// depends on rme_pkg and the core rtl; every result is checked against a square-and-multiply predictor
module testbench;

    localparam int DATA_W = 32;
    localparam int APB_DW = 32;
    localparam int ADDR_W = 4;

    // out-of-range register index, writes to it must be dropped
    localparam logic [1:0] REG_NONE = 2'd3;

    localparam int RANDOM_ITEMS = 272;
    localparam int DRAIN_CYCLES = 2500;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              modulus_error;
    } power_result_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_BLOCKED
    } rx_mode_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // value_in
    logic              s_tuser  = 1'b0; // opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // value_out
    logic              m_tuser;         // modulus_error

    // shadow copy of the key registers
    logic [DATA_W-1:0] key_modulus = 32'd1;
    logic [DATA_W-1:0] key_public  = 32'd1;
    logic [DATA_W-1:0] key_private = 32'd1;

    power_result_t predicted_powers[$];
    int            mismatch_count = 0;
    int            burst_left     = 0;
    rx_mode_t      rx_mode        = RX_OPEN;
    int            rx_left        = 0;

    rsa_modular_exponentiation_core #(
        .WIDTH(DATA_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20-unit clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // base ^ exponent mod n, msb-first square-and-multiply on exact 64-bit products
    function automatic logic [DATA_W-1:0] rsa_power_mod(logic [DATA_W-1:0] base,
                                                        logic [DATA_W-1:0] exponent,
                                                        logic [DATA_W-1:0] n);
        logic [63:0] acc;
        logic [63:0] b;
        logic [63:0] n64;
        n64 = {32'd0, n};
        acc = 64'd1 % n64;
        b   = {32'd0, base} % n64;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            acc = (acc * acc) % n64;
            if (exponent[i])
                acc = (acc * b) % n64;
        end
        return acc[DATA_W-1:0];
    endfunction

    function automatic power_result_t predict_power(logic op, logic [DATA_W-1:0] value);
        power_result_t res;
        logic [DATA_W-1:0] exponent;
        exponent = (op == rme_pkg::OP_DECRYPT) ? key_private : key_public;
        if (key_modulus == '0) begin
            res.value         = '0;
            res.modulus_error = 1'b1;
        end else begin
            res.value         = rsa_power_mod(value, exponent, key_modulus);
            res.modulus_error = 1'b0;
        end
        return res;
    endfunction

    // result check first, then record the beat taken on the input side
    always @(posedge aclk) begin : check_results
        power_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (predicted_powers.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing outstanding, expected none actual %h/%b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = predicted_powers.pop_front();
                    if (m_tdata !== want.value) begin
                        mismatch_count++;
                        $display("%0t: value_out mismatch, expected %h actual %h",
                                 $time, want.value, m_tdata);
                    end
                    if (m_tuser !== want.modulus_error) begin
                        mismatch_count++;
                        $display("%0t: modulus_error mismatch, expected %b actual %b",
                                 $time, want.modulus_error, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_powers.push_back(predict_power(s_tuser, s_tdata));
        end
    end

    // receiver backpressure: open, choppy and blocked stretches of random length
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1:    rx_mode = RX_BLOCKED;
                2, 3, 4: rx_mode = RX_CHOPPY;
                default: rx_mode = RX_OPEN;
            endcase
            rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 1500) : $urandom_range(1, 4000);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_BLOCKED: m_tready <= 1'b0;
            default:    m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // one input beat, with burst gaps; starts and ends on a falling edge
    task automatic send_beat(input logic op, input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 2500) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 6);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (predicted_powers.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            rme_pkg::REG_MODULUS:     key_modulus = value;
            rme_pkg::REG_PUBLIC_EXP:  key_public  = value;
            rme_pkg::REG_PRIVATE_EXP: key_private = value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // read one register and compare with the shadow copy
    task automatic reg_check(input logic [1:0] idx);
        logic [APB_DW-1:0] want;
        want = (idx == rme_pkg::REG_MODULUS) ? key_modulus :
               (idx == rme_pkg::REG_PUBLIC_EXP) ? key_public : key_private;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            mismatch_count++;
            $display("%0t: register %0d readback mismatch, expected %h actual %h",
                     $time, idx, want, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_key(input logic [DATA_W-1:0] n, input logic [DATA_W-1:0] e,
                            input logic [DATA_W-1:0] d);
        wait_idle();
        reg_write(rme_pkg::REG_MODULUS, n);
        reg_write(rme_pkg::REG_PUBLIC_EXP, e);
        reg_write(rme_pkg::REG_PRIVATE_EXP, d);
    endtask

    // registers come out of reset at 1, so every result is 0
    task automatic test_reset_defaults();
        reg_check(rme_pkg::REG_MODULUS);
        reg_check(rme_pkg::REG_PUBLIC_EXP);
        reg_check(rme_pkg::REG_PRIVATE_EXP);
        send_beat(rme_pkg::OP_ENCRYPT, 32'hFFFF_FFFF);
        send_beat(rme_pkg::OP_DECRYPT, 32'd5);
    endtask

    // write and read back, and a write past the last register changes nothing
    task automatic test_register_access();
        load_key(32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'h1234_5678);
        reg_check(rme_pkg::REG_MODULUS);
        reg_check(rme_pkg::REG_PUBLIC_EXP);
        reg_check(rme_pkg::REG_PRIVATE_EXP);
        reg_write(REG_NONE, 32'hDEAD_BEEF);
        reg_check(rme_pkg::REG_MODULUS);
        reg_check(rme_pkg::REG_PUBLIC_EXP);
        reg_check(rme_pkg::REG_PRIVATE_EXP);
    endtask

    // field extremes, zero exponent, value above modulus, tiny and zero modulus
    task automatic test_directed_cases();
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0001);
        send_beat(rme_pkg::OP_ENCRYPT, 32'd0);
        send_beat(rme_pkg::OP_ENCRYPT, 32'd1);
        send_beat(rme_pkg::OP_ENCRYPT, 32'hFFFF_FFFF);
        send_beat(rme_pkg::OP_DECRYPT, 32'hFFFF_FFFE);
        send_beat(rme_pkg::OP_DECRYPT, 32'h8000_0000);
        load_key(32'hFFFF_FFFB, 32'd0, 32'd0);
        send_beat(rme_pkg::OP_ENCRYPT, 32'd12345);
        send_beat(rme_pkg::OP_DECRYPT, 32'd0);
        send_beat(rme_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
        load_key(32'd1, 32'd3, 32'd0);
        send_beat(rme_pkg::OP_ENCRYPT, 32'd7);
        send_beat(rme_pkg::OP_DECRYPT, 32'd0);
        load_key(32'd2, 32'd1, 32'hFFFF_FFFF);
        send_beat(rme_pkg::OP_ENCRYPT, 32'd3);
        send_beat(rme_pkg::OP_DECRYPT, 32'hFFFF_FFFE);
        load_key(32'd0, 32'd17, 32'd5);
        send_beat(rme_pkg::OP_ENCRYPT, 32'd100);
        send_beat(rme_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
        // textbook key pair: n = 61 * 53
        load_key(32'd3233, 32'd17, 32'd2753);
        send_beat(rme_pkg::OP_ENCRYPT, 32'd65);
        send_beat(rme_pkg::OP_DECRYPT, 32'd2790);
    endtask

    function automatic logic [DATA_W-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom_range(1, 70000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(logic [DATA_W-1:0] n);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return (n != '0) ? $urandom % n : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // random keys in phases, each phase a burst of random beats
    task automatic test_random_keys();
        int               sent;
        int               count;
        logic [DATA_W-1:0] n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       n = '0;
                1:       n = DATA_W'($urandom_range(1, 300));
                2:       n = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
                default: n = $urandom;
            endcase
            load_key(n, pick_exponent(), pick_exponent());
            count = (n == '0) ? $urandom_range(2, 6) : $urandom_range(20, 50);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            repeat (count)
                send_beat(1'($urandom_range(0, 1)), pick_value(n));
            sent += count;
        end
    endtask

    // main sequence
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_register_access();
        test_directed_cases();
        test_random_keys();
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
